// ===== rtl/xns_pkg.sv =====
`default_nettype none
package xns_pkg;

   localparam int unsigned MaxNameBytes = 4095;
   localparam int unsigned LenWidth     = 12;
   localparam int unsigned CpWidth      = 21;
   localparam int unsigned LenCapInt    = (MaxNameBytes > 4095) ? 4095 : MaxNameBytes;
   localparam logic [LenWidth-1:0] LenCap = LenWidth'(LenCapInt);

   localparam logic [1:0] ContTag  = 2'h2;
   localparam logic [2:0] Lead2Tag = 3'h6;
   localparam logic [3:0] Lead3Tag = 4'hE;
   localparam logic [4:0] Lead4Tag = 5'h1E;

   typedef struct packed {
      logic                complete;
      logic                valid;
      logic [CpWidth-1:0]  cp;
      logic [2:0]          nbytes;
   } char_info_type;

   typedef struct packed {
      logic                char_complete;
      logic [CpWidth-1:0]  codepoint;
      logic                char_accepted;
      logic                name_done;
      logic [LenWidth-1:0] name_length;
      logic                name_overflow;
      logic                scan_active;
   } result_type;

   function automatic logic is_start_char(input logic [CpWidth-1:0] cp);
      logic hit;
      begin
         if (cp < 21'h80) begin
            hit = (cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A) ||
                  cp == 21'h5F || cp == 21'h3A;
         end else begin
            hit = (cp >= 21'hC0    && cp <= 21'hD6)    ||
                  (cp >= 21'hD8    && cp <= 21'hF6)    ||
                  (cp >= 21'hF8    && cp <= 21'h2FF)   ||
                  (cp >= 21'h370   && cp <= 21'h37D)   ||
                  (cp >= 21'h37F   && cp <= 21'h1FFF)  ||
                  (cp >= 21'h200C  && cp <= 21'h200D)  ||
                  (cp >= 21'h2070  && cp <= 21'h218F)  ||
                  (cp >= 21'h2C00  && cp <= 21'h2FEF)  ||
                  (cp >= 21'h3001  && cp <= 21'hD7FF)  ||
                  (cp >= 21'hF900  && cp <= 21'hFDCF)  ||
                  (cp >= 21'hFDF0  && cp <= 21'hFFFD)  ||
                  (cp >= 21'h10000 && cp <= 21'hEFFFF);
         end
         return hit;
      end
   endfunction

   function automatic logic is_name_char(input logic [CpWidth-1:0] cp);
      logic hit;
      begin
         if (cp < 21'h80) begin
            hit = is_start_char(cp) || (cp >= 21'h30 && cp <= 21'h39) ||
                  cp == 21'h2D || cp == 21'h2E;
         end else begin
            hit = is_start_char(cp) || cp == 21'hB7 ||
                  (cp >= 21'h300 && cp <= 21'h36F) ||
                  (cp >= 21'h203F && cp <= 21'h2040);
         end
         return hit;
      end
   endfunction

endpackage
`default_nettype wire

// ===== rtl/xns_decode.sv =====
`default_nettype none
module xns_decode (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  start_scan,
   input  wire logic [7:0]            data_byte,
   output xns_pkg::char_info_type     info
);

   logic [1:0]                   pending_ff, pending_in, pending_eff;
   logic [xns_pkg::CpWidth-1:0]  partial_ff, partial_in, partial_eff, joined;
   logic [2:0]                   count_ff, count_in, count_eff;

   assign pending_eff = start_scan ? 2'd0 : pending_ff;
   assign partial_eff = start_scan ? '0 : partial_ff;
   assign count_eff   = start_scan ? 3'd0 : count_ff;
   assign joined      = {partial_eff[xns_pkg::CpWidth-7:0], data_byte[5:0]};

   always_comb begin
      pending_in  = pending_eff;
      partial_in  = partial_eff;
      count_in    = count_eff;
      info        = '0;
      if (pending_eff == 2'd0) begin
         priority if (data_byte[7] == 1'b0) begin
            info.complete = 1'b1;
            info.valid    = 1'b1;
            info.cp       = xns_pkg::CpWidth'(data_byte);
            info.nbytes   = 3'd1;
         end else if (data_byte[7:5] == xns_pkg::Lead2Tag) begin
            pending_in = 2'd1;
            partial_in = xns_pkg::CpWidth'(data_byte[4:0]);
            count_in   = 3'd2;
         end else if (data_byte[7:4] == xns_pkg::Lead3Tag) begin
            pending_in = 2'd2;
            partial_in = xns_pkg::CpWidth'(data_byte[3:0]);
            count_in   = 3'd3;
         end else if (data_byte[7:3] == xns_pkg::Lead4Tag) begin
            pending_in = 2'd3;
            partial_in = xns_pkg::CpWidth'(data_byte[2:0]);
            count_in   = 3'd4;
         end else begin
            info.complete = 1'b1;
            info.nbytes   = 3'd1;
         end
      end else if (data_byte[7:6] == xns_pkg::ContTag) begin
         pending_in = pending_eff - 2'd1;
         partial_in = joined;
         if (pending_eff == 2'd1) begin
            info.complete = 1'b1;
            info.nbytes   = count_eff;
            priority if (count_eff == 3'd2) begin
               info.valid = joined >= 21'h80;
            end else if (count_eff == 3'd3) begin
               info.valid = joined >= 21'h800 && (joined < 21'hD800 || joined > 21'hDFFF);
            end else begin
               info.valid = joined >= 21'h10000 && joined <= 21'h10FFFF;
            end
            info.cp = info.valid ? joined : '0;
         end
      end else begin
         info.complete = 1'b1;
         info.nbytes   = count_eff;
         pending_in    = 2'd0;
      end
      if (info.complete) begin
         partial_in = '0;
         count_in   = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         partial_ff <= '0;
         count_ff   <= 3'd0;
      end else if (advance) begin
         pending_ff <= pending_in;
         partial_ff <= partial_in;
         count_ff   <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/xns_scan.sv =====
`default_nettype none
module xns_scan (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic                  start_scan,
   input  wire xns_pkg::char_info_type info,
   output logic                       scan_live,
   output xns_pkg::result_type        result
);

   logic                          scanning_ff, scanning_in;
   logic                          first_ff, first_in, first_eff;
   logic [xns_pkg::LenWidth-1:0]  length_ff, length_in, length_eff;
   logic                          ovf_ff, ovf_in, ovf_eff;
   logic [xns_pkg::LenWidth:0]    sum;
   logic                          class_ok;

   assign scan_live  = start_scan | scanning_ff;
   assign first_eff  = start_scan | first_ff;
   assign length_eff = start_scan ? '0 : length_ff;
   assign ovf_eff    = ~start_scan & ovf_ff;
   assign sum        = {1'b0, length_eff} + (xns_pkg::LenWidth + 1)'(info.nbytes);
   assign class_ok   = first_eff ? xns_pkg::is_start_char(info.cp)
                                 : xns_pkg::is_name_char(info.cp);

   always_comb begin
      scanning_in = scan_live;
      first_in    = first_eff;
      length_in   = length_eff;
      ovf_in      = ovf_eff;
      result      = '0;
      if (scan_live) begin
         if (info.complete) begin
            result.char_complete = 1'b1;
            result.codepoint     = info.cp;
            if (info.valid && class_ok) begin
               result.char_accepted = 1'b1;
               first_in             = 1'b0;
               if (sum > {1'b0, xns_pkg::LenCap}) begin
                  length_in = xns_pkg::LenCap;
                  ovf_in    = 1'b1;
               end else begin
                  length_in = sum[xns_pkg::LenWidth-1:0];
               end
            end else begin
               result.name_done = 1'b1;
               scanning_in      = 1'b0;
            end
         end
         result.name_length   = length_in;
         result.name_overflow = ovf_in;
         result.scan_active   = scanning_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scanning_ff <= 1'b0;
         first_ff    <= 1'b1;
         length_ff   <= '0;
         ovf_ff      <= 1'b0;
      end else if (accept && scan_live) begin
         scanning_ff <= scanning_in;
         first_ff    <= first_in;
         length_ff   <= length_in;
         ovf_ff      <= ovf_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/xml_name_scanner_utf8_unit.sv =====
// An accepted byte's result word is registered and shows on rsp_ from the next cycle.
// Throughput: one byte per cycle while req_tready is high; decode, classification
// and length update sit between the scan state registers and a single result register.
// req_tready stays high while the result register is empty or being taken.
// Reset (synchronous, active high) empties the result register, drops any
// partial character and leaves the scanner idle.
`default_nettype none
module xml_name_scanner_utf8_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] start_scan
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [0] char_complete, [21:1] codepoint,
                                         // [22] char_accepted, [34:23] name_length,
                                         // [35] name_overflow, [36] scan_active, [39:37] zero
   output logic             rsp_tlast    // name_done
);

   logic                    accept;
   logic                    scan_live;
   xns_pkg::char_info_type  info;
   xns_pkg::result_type     result;
   xns_pkg::result_type     out_ff;
   logic                    valid_ff, valid_in;

   assign req_tready = ~valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign valid_in   = accept | (valid_ff & ~rsp_tready);

   xns_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept & scan_live),
      .start_scan (req_tuser),
      .data_byte  (req_tdata),
      .info       (info)
   );

   xns_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .start_scan (req_tuser),
      .info       (info),
      .scan_live  (scan_live),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = out_ff.name_done;
   assign rsp_tdata  = {3'b000, out_ff.scan_active, out_ff.name_overflow, out_ff.name_length,
                        out_ff.char_accepted, out_ff.codepoint, out_ff.char_complete};

endmodule
`default_nettype wire

// ===== rtl/xns_checker.sv =====
`default_nettype none
module xns_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tdata[36] && rsp_tdata[0] && !rsp_tdata[22])
      else $error("name end without a rejected completed character");

   a_accept_complete: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[22] |-> rsp_tdata[0] && rsp_tdata[36])
      else $error("accepted character not complete or scan idle");

   a_partial_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[21:1] == 21'h0 && !rsp_tlast)
      else $error("codepoint or end flag on an incomplete character");

   a_ovf_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35] |-> rsp_tdata[34:23] == xns_pkg::LenCap)
      else $error("overflow without length at cap");

endmodule

bind xml_name_scanner_utf8_unit xns_checker u_xns_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
